### rtl/kcr_pkg.sv
// shared types and constants of the keypoint color ramp
`default_nettype none

package kcr_pkg;

  // field widths
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned POINT_W   = TIME_W + 3 * COLOR_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = POINT_W;

  // color fixed point format
  localparam int unsigned COLOR_FRAC_BITS = 12;
  localparam int unsigned COLOR_ONE       = 1 << COLOR_FRAC_BITS;
  localparam logic [COLOR_W-1:0] DEF_RED   = COLOR_W'((4 * COLOR_ONE + 5) / 10);
  localparam logic [COLOR_W-1:0] DEF_GREEN = COLOR_W'((7 * COLOR_ONE + 5) / 10);
  localparam logic [COLOR_W-1:0] DEF_BLUE  = COLOR_W'(COLOR_ONE);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd2;

  // interpolation modes
  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;

  // blend arithmetic widths
  localparam int unsigned DIFF_W = TIME_W + 1;        // signed time difference
  localparam int unsigned PROD_W = 2 * DIFF_W;        // signed product
  localparam int unsigned NUM_W  = PROD_W + 1;        // signed sum of products
  localparam int unsigned TOP_W  = NUM_W + 1;         // 2*num + d
  localparam int unsigned DIV_W  = TIME_W + 1;        // divisor 2*d
  localparam int unsigned QUO_W  = COLOR_W;

  // divider pipeline
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  // pipeline stage numbers
  localparam int unsigned ST_SEL     = 0;
  localparam int unsigned ST_OPER    = 1;
  localparam int unsigned ST_MUL     = 2;
  localparam int unsigned ST_SUM     = 3;
  localparam int unsigned ST_DIVSET  = 4;
  localparam int unsigned ST_OUT     = ST_DIVSET + DIV_STAGES + 1;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  typedef logic [2:0][COLOR_W-1:0] rgb_t;   // [0] red, [1] green, [2] blue
  typedef logic [POINT_W-1:0] point_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] num_lo;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic             blend;
    logic [2:0]       neg;
    logic [2:0]       ovf;
    logic [DIV_W-1:0] dv;
    rgb_t             fix;
  } side_t;

  function automatic logic [TIME_W-1:0] pt_time(input point_t p);
    return p[POINT_W-1 -: TIME_W];
  endfunction

  function automatic rgb_t pt_color(input point_t p);
    rgb_t c;
    c[0] = p[3*COLOR_W-1 -: COLOR_W];
    c[1] = p[2*COLOR_W-1 -: COLOR_W];
    c[2] = p[COLOR_W-1 -: COLOR_W];
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/keypoint_color_ramp_unit.sv
// top level of the keypoint color ramp: config registers and lookup pipeline
`default_nettype none

// Maps a 16-bit query time in seconds to an RGB color (three unsigned Q4.12
// channels) through up to MAX_POINTS keypoints held in config registers.
// Mode 0, or fewer than two points, answers the default color; mode 1 (and
// 3) answers the upper bracketing keypoint; mode 2 blends the bracketing
// pair when its span is positive, extrapolates past the last point and
// saturates each channel to 0..65535, rounding to nearest with ties upward.
// The lookup is a fully pipelined path of ten register stages: keypoint
// selection, operand fetch, multiply, sum, divider setup, four divider
// stages of four quotient bits each, and the output register. One request
// is taken every clock unless the output holds. Each stage stalls only while
// it is full and the stage after it holds, so bubbles close up and the input
// keeps taking requests while a result waits. Configuration must be written
// only while no request is in flight; the block itself does not enforce it.
module keypoint_color_ramp_unit #(
  parameter int unsigned MAX_POINTS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [kcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kcr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,   // time_seconds
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata    // red, green, blue
);
  import kcr_pkg::*;

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [2:0]  MAX_CNT = 3'(MAX_POINTS);

  // config registers
  logic [1:0] mode_q;
  logic [2:0] count_q;
  point_t     point_q [MAX_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CONST;
      count_q <= '0;
      for (int k = 0; k < MAX_POINTS; k++) begin
        point_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_wdata_i[1:0];
        REG_COUNT: count_q <= cfg_wdata_i[2:0];
        default: begin
          // point registers past MAX_POINTS are never read, so not kept
          for (int k = 0; k < MAX_POINTS; k++) begin
            if (cfg_index_i == REG_POINT0 + CFG_IDX_W'(k)) begin
              point_q[k] <= cfg_wdata_i;
            end
          end
        end
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[ST_SEL]) begin
        v_q[ST_SEL] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // stage 0: keypoint selection walk
  logic [2:0]        n_cnt;
  logic [IDX_W-1:0]  lo_d, up_d;
  logic              dflt_d;
  logic [TIME_W-1:0] t0_q;
  logic [IDX_W-1:0]  lo0_q, up0_q;
  logic              dflt0_q;

  always_comb begin
    n_cnt  = (count_q > MAX_CNT) ? MAX_CNT : count_q;
    dflt_d = (n_cnt < 3'd2) || (mode_q == MODE_CONST);
    lo_d   = '0;
    up_d   = '0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      if ((3'(i) < n_cnt) && (s_axis_tdata > pt_time(point_q[i-1]))) begin
        lo_d = up_d;
        up_d = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SEL]) begin
      t0_q    <= s_axis_tdata;
      lo0_q   <= lo_d;
      up0_q   <= up_d;
      dflt0_q <= dflt_d;
    end
  end

  // stage 1: fetch bracketing points, time differences
  point_t                   plo, pup;
  logic [TIME_W-1:0]        tlo, tup;
  logic signed [DIFF_W-1:0] da_d, db_d;
  logic                     blend_d;
  rgb_t                     fix_d;
  rgb_t                     clo1_q, cup1_q;
  logic signed [DIFF_W-1:0] da1_q, db1_q;
  logic [TIME_W-1:0]        d1_q;
  logic                     blend1_q;
  rgb_t                     fix1_q;

  always_comb begin
    plo     = point_q[lo0_q];
    pup     = point_q[up0_q];
    tlo     = pt_time(plo);
    tup     = pt_time(pup);
    da_d    = $signed({1'b0, tup}) - $signed({1'b0, t0_q});
    db_d    = $signed({1'b0, t0_q}) - $signed({1'b0, tlo});
    blend_d = !dflt0_q && (mode_q == MODE_LINEAR) && (tup > tlo);
    if (dflt0_q) begin
      fix_d = {DEF_BLUE, DEF_GREEN, DEF_RED};
    end else begin
      fix_d = pt_color(pup);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OPER]) begin
      clo1_q   <= pt_color(plo);
      cup1_q   <= pt_color(pup);
      da1_q    <= da_d;
      db1_q    <= db_d;
      d1_q     <= tup - tlo;
      blend1_q <= blend_d;
      fix1_q   <= fix_d;
    end
  end

  // stage 2: weight products per channel
  logic signed [DIFF_W-1:0] clo_s [3];
  logic signed [DIFF_W-1:0] cup_s [3];
  logic signed [PROD_W-1:0] pa_d  [3];
  logic signed [PROD_W-1:0] pb_d  [3];
  logic signed [PROD_W-1:0] pa2_q [3];
  logic signed [PROD_W-1:0] pb2_q [3];
  logic [TIME_W-1:0]        d2_q;
  logic                     blend2_q;
  rgb_t                     fix2_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      clo_s[c] = $signed({1'b0, clo1_q[c]});
      cup_s[c] = $signed({1'b0, cup1_q[c]});
      pa_d[c]  = clo_s[c] * da1_q;
      pb_d[c]  = cup_s[c] * db1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      for (int c = 0; c < 3; c++) begin
        pa2_q[c] <= pa_d[c];
        pb2_q[c] <= pb_d[c];
      end
      d2_q     <= d1_q;
      blend2_q <= blend1_q;
      fix2_q   <= fix1_q;
    end
  end

  // stage 3: rounded dividend 2*num + d
  logic signed [NUM_W-1:0] num_d [3];
  logic [TOP_W-1:0]        top_d [3];
  logic [TOP_W-1:0]        top3_q [3];
  logic [TIME_W-1:0]       d3_q;
  logic                    blend3_q;
  rgb_t                    fix3_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_d[c] = pa2_q[c] + pb2_q[c];
      top_d[c] = {num_d[c], 1'b0} + {{(TOP_W-TIME_W){1'b0}}, d2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      for (int c = 0; c < 3; c++) begin
        top3_q[c] <= top_d[c];
      end
      d3_q     <= d2_q;
      blend3_q <= blend2_q;
      fix3_q   <= fix2_q;
    end
  end

  // stage 4: sign and saturation checks, divider setup
  // divr_q[j] and side_q[j] belong to stage ST_DIVSET + j
  div_t             div0_d [3];
  div_t             divr_d [1:DIV_STAGES][3];
  div_t             divr_q [DIV_STAGES+1][3];
  side_t            side_d;
  side_t            side_q [DIV_STAGES+1];
  logic [DIV_W-1:0] dv_d;

  always_comb begin
    dv_d         = {d3_q, 1'b0};
    side_d.blend = blend3_q;
    side_d.dv    = dv_d;
    side_d.fix   = fix3_q;
    for (int c = 0; c < 3; c++) begin
      side_d.neg[c] = top3_q[c][TOP_W-1];
      // quotient above 16 bits when the dividend's upper part reaches 2*d
      side_d.ovf[c] = !top3_q[c][TOP_W-1] &&
                      (top3_q[c][TOP_W-2:QUO_W] >=
                       {{(TOP_W-1-QUO_W-DIV_W){1'b0}}, dv_d});
      div0_d[c].rem    = top3_q[c][QUO_W+DIV_W-1:QUO_W];
      div0_d[c].num_lo = top3_q[c][QUO_W-1:0];
      div0_d[c].quo    = '0;
    end
  end

  // divider stages
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    for (genvar c = 0; c < 3; c++) begin : g_ch
      kcr_div_stage u_div (
        .div_i     (divr_q[k-1][c]),
        .divisor_i (side_q[k-1].dv),
        .div_o     (divr_d[k][c])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIVSET]) begin
      side_q[0] <= side_d;
      for (int c = 0; c < 3; c++) begin
        divr_q[0][c] <= div0_d[c];
      end
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[ST_DIVSET+k]) begin
        side_q[k] <= side_q[k-1];
        for (int c = 0; c < 3; c++) begin
          divr_q[k][c] <= divr_d[k][c];
        end
      end
    end
  end

  // output stage: pick fixed color, clamp or quotient
  rgb_t out_d, out_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!side_q[DIV_STAGES].blend) begin
        out_d[c] = side_q[DIV_STAGES].fix[c];
      end else if (side_q[DIV_STAGES].neg[c]) begin
        out_d[c] = '0;
      end else if (side_q[DIV_STAGES].ovf[c]) begin
        out_d[c] = '1;
      end else begin
        out_d[c] = divr_q[DIV_STAGES][c].quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tdata  = out_q;

  // a free output side never holds back the input
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  // input only stalls once every stage holds a request
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // a blended request always has a nonzero time span
  a_blend_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_OPER] && blend1_q) |-> (d1_q != '0))
    else $error("blend selected with empty time span");

  // divider remainder stays below the divisor on the live path
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_DIVSET+1] && side_q[1].blend && !side_q[1].neg[0] && !side_q[1].ovf[0])
      |-> (divr_q[1][0].rem < side_q[1].dv))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

### rtl/kcr_div_stage.sv
// one stage of the restoring divider, several quotient bits per stage
`default_nettype none

module kcr_div_stage (
  input  kcr_pkg::div_t              div_i,
  input  logic [kcr_pkg::DIV_W-1:0]  divisor_i,
  output kcr_pkg::div_t              div_o
);
  import kcr_pkg::*;

  always_comb begin
    div_t           cur;
    logic [DIV_W:0] trial;
    cur   = div_i;
    trial = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial      = {cur.rem, cur.num_lo[QUO_W-1]};
      cur.num_lo = {cur.num_lo[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial   = trial - {1'b0, divisor_i};
        cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
      end else begin
        cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
      end
      // remainder stays below the divisor
      cur.rem = trial[DIV_W-1:0];
    end
    div_o = cur;
  end

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench of the keypoint color ramp unit
`default_nettype none

module tb;
  import kcr_pkg::*;

  localparam int MAX_KEYS    = 6;
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off, fills the pipeline
  localparam int CYCLE_LIMIT = 500000;  // far above the slowest correct run
  localparam int NUM_PHASES  = 24;
  localparam int PHASE_ITEMS = 75;
  localparam int QUIET_FROM  = 21;      // last phases run without idling

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // time_seconds
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;   // red, green, blue

  keypoint_color_ramp_unit #(.MAX_POINTS(MAX_KEYS)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow copy of the config registers
  logic [1:0]  mode_r;
  logic [2:0]  count_r;
  logic [63:0] keys [MAX_KEYS];
  logic [63:0] tbl_pend [MAX_KEYS];   // table staged for the next config pass

  logic [15:0] time_q [$];    // query times waiting for the driver
  rgb_t        color_q [$];   // predicted colors waiting for results
  int          in_flight;     // queued but not yet answered
  int          err_cnt;
  int          res_cnt;
  int          cycle_cnt;
  int          q_lo, q_hi;    // range of table times for query shaping
  bit          quiet;         // no idling on either side
  bit          in_taken;      // driver's request was accepted at the last edge
  int          src_idle;
  int          snk_idle;
  bit          snk_rdy;
  bit          hold_start;
  int          hold_cnt;
  string       chan_name [3] = '{"red", "green", "blue"};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] key_time(input logic [63:0] p);
    return p[63:48];
  endfunction

  // channel 0 is red at [47:32], blue sits in the low bits
  function automatic logic [15:0] key_chan(input logic [63:0] p, input int ch);
    return 16'(p >> (32 - 16 * ch));
  endfunction

  function automatic logic [63:0] mk_key(input logic [15:0] t, input logic [15:0] r,
                                         input logic [15:0] g, input logic [15:0] b);
    return {t, r, g, b};
  endfunction

  // rounded blend of one channel, ties upward, clamped to 16 bits
  function automatic logic [15:0] blend_chan(input longint cl, input longint cu,
                                             input longint tl, input longint tu,
                                             input longint t);
    longint d, num, top, q;
    d   = tu - tl;
    num = cl * (tu - t) + cu * (t - tl);
    top = 2 * num + d;
    if (top < 0) return 16'h0000;
    q = top / (2 * d);
    return (q > 65535) ? 16'hFFFF : 16'(q);
  endfunction

  // expected color for one query time under the current shadow config
  function automatic rgb_t ramp_color(input logic [15:0] t);
    int   n, lo, up;
    int   one;
    rgb_t c;
    one = 1 << COLOR_FRAC_BITS;
    n = (count_r > MAX_KEYS) ? MAX_KEYS : count_r;
    if (n < 2 || mode_r == MODE_CONST) begin
      c[0] = 16'((4 * one + 5) / 10);
      c[1] = 16'((7 * one + 5) / 10);
      c[2] = 16'(one);
      return c;
    end
    lo = 0;
    up = 0;
    // bracketing walk, applied as is to unordered tables
    for (int i = 1; i < n; i++) begin
      if (t > key_time(keys[i-1])) begin
        lo = up;
        up = i;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (mode_r == MODE_LINEAR && key_time(keys[up]) > key_time(keys[lo]))
        c[ch] = blend_chan(key_chan(keys[lo], ch), key_chan(keys[up], ch),
                           key_time(keys[lo]), key_time(keys[up]), t);
      else
        c[ch] = key_chan(keys[up], ch);   // step mode, mode 3, or no positive span
    end
    return c;
  endfunction

  // one register write per falling edge; caller drops the enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_MODE) mode_r = val[1:0];
    else if (idx == REG_COUNT) count_r = val[2:0];
    else keys[idx - REG_POINT0] = val;
    @(negedge clk_i);
  endtask

  // writes mode, count and the staged table; block must be idle
  task automatic write_table(input logic [63:0] mode_val, input logic [63:0] count_val);
    write_reg(REG_MODE, mode_val);
    write_reg(REG_COUNT, count_val);
    for (int i = 0; i < MAX_KEYS; i++)
      write_reg(REG_POINT0 + CFG_IDX_W'(i), tbl_pend[i]);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic post_time(input logic [15:0] t);
    time_q = {time_q, t};
    in_flight++;
  endtask

  task automatic wait_drained;
    while (in_flight != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_chan;
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // random table: mostly ascending, sometimes narrow or unordered
  task automatic rand_table;
    int t, kind, span;
    kind = $urandom_range(0, 5);
    span = (kind == 1) ? 20 : 13000;
    t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15000);
    q_lo = 65535;
    q_hi = 0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (kind == 0) t = $urandom_range(0, 65535);
      tbl_pend[i] = mk_key(16'(t), rand_chan(), rand_chan(), rand_chan());
      if (t < q_lo) q_lo = t;
      if (t > q_hi) q_hi = t;
      if (kind != 0) begin
        t = t + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, span));
        if (t > 65535) t = 65535;
      end
    end
  endtask

  // query shaped around the table, with boundary hits and full-range noise
  function automatic logic [15:0] rand_query;
    int a, b, k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      a = (q_lo > 500) ? q_lo - 500 : 0;
      b = (q_hi < 65035) ? q_hi + 500 : 65535;
      return 16'($urandom_range(a, b));
    end else if (k < 8) begin
      a = key_time(keys[$urandom_range(0, MAX_KEYS - 1)]) + $urandom_range(0, 2) - 1;
      return 16'(a);
    end
    return 16'($urandom);
  endfunction

  // request driver: offers the next queued time once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (src_idle > 0) begin
        src_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (time_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          src_idle = $urandom_range(0, 9);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tdata  <= time_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // long hold-off counter, own process so the sender keeps pushing meanwhile
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_cnt   = HOLD_CYCLES;
      hold_start = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
  end

  // result ready with random stall bursts
  always @(negedge clk_i) begin
    if (snk_idle > 0) begin
      snk_idle--;
      snk_rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      snk_idle = $urandom_range(0, 9);
      snk_rdy  = 1'b0;
    end else begin
      snk_rdy = 1'b1;
    end
    m_axis_tready <= snk_rdy && (hold_cnt == 0);
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk_i) begin
    rgb_t exp_c, got_c;
    cycle_cnt++;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        color_q = {color_q, ramp_color(s_axis_tdata)};
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        in_flight--;
        res_cnt++;
        got_c = m_axis_tdata;
        if (color_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d: unexpected, got %h", res_cnt, m_axis_tdata);
        end else begin
          exp_c = color_q.pop_front();
          if (got_c != exp_c) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              for (int ch = 0; ch < 3; ch++)
                if (got_c[ch] != exp_c[ch])
                  $display("result %0d %s: expected %0d, got %0d",
                           res_cnt, chan_name[ch], exp_c[ch], got_c[ch]);
            end
          end
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mode_r        = MODE_CONST;
    count_r       = '0;
    for (int i = 0; i < MAX_KEYS; i++) keys[i] = '0;
    in_flight  = 0;
    err_cnt    = 0;
    res_cnt    = 0;
    cycle_cnt  = 0;
    quiet      = 1'b0;
    in_taken   = 1'b0;
    src_idle   = 0;
    snk_idle   = 0;
    hold_start = 1'b0;
    hold_cnt   = 0;
    q_lo       = 0;
    q_hi       = 65535;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset value: default color
    post_time(16'd0);
    post_time(16'hFFFF);
    wait_drained();

    // ascending table with a repeated time and channel extremes
    tbl_pend[0] = mk_key(16'd100,   16'h0000, 16'hFFFF, 16'h1000);
    tbl_pend[1] = mk_key(16'd300,   16'hFFFF, 16'h0000, 16'h04D2);
    tbl_pend[2] = mk_key(16'd301,   16'h8000, 16'h7FFF, 16'h0001);
    tbl_pend[3] = mk_key(16'd5000,  16'h1234, 16'hABCD, 16'h0FFF);
    tbl_pend[4] = mk_key(16'd5000,  16'hFFFF, 16'h0000, 16'h7530);
    tbl_pend[5] = mk_key(16'd60000, 16'h0000, 16'hFFFF, 16'h7531);
    write_table(64'(MODE_LINEAR), 64'd6);
    // before, on and between keys, then extrapolation with clamping both ways
    post_time(16'd0);
    post_time(16'd100);
    post_time(16'd101);
    post_time(16'd200);
    post_time(16'd300);
    post_time(16'd301);
    post_time(16'd2000);
    post_time(16'd5000);
    post_time(16'd5001);
    post_time(16'd60000);
    post_time(16'hFFFF);
    wait_drained();

    // step mode
    write_table(64'(MODE_STEP), 64'd6);
    post_time(16'd0);
    post_time(16'd150);
    post_time(16'd5000);
    post_time(16'hFFFF);
    wait_drained();

    // unused selector behaves as step, upper bits of the write ignored
    write_table({62'h3FFF_FFFF_FFFF_FFFF, 2'd3}, 64'd6);
    post_time(16'd150);
    post_time(16'hFFFF);
    wait_drained();

    // single key in use: default color
    write_table(64'(MODE_LINEAR), 64'd1);
    post_time(16'd500);
    wait_drained();

    // count above the table size clamps to six
    write_table(64'(MODE_LINEAR), {61'h1, 3'd7});
    post_time(16'hFFFF);
    post_time(16'd1000);
    wait_drained();

    // two equal times bracketing: zero span answers the upper key
    write_table(64'(MODE_LINEAR), 64'd5);
    post_time(16'd6000);
    wait_drained();

    // constant mode with a full table
    write_table(64'(MODE_CONST), 64'd6);
    post_time(16'd200);
    wait_drained();

    // unordered table: negative span
    tbl_pend[0] = mk_key(16'd40000, 16'h1111, 16'h2222, 16'h3333);
    tbl_pend[1] = mk_key(16'd10000, 16'hFFFF, 16'h0000, 16'h8000);
    tbl_pend[2] = mk_key(16'd50000, 16'h0000, 16'hFFFF, 16'h4000);
    write_table(64'(MODE_LINEAR), 64'd6);
    post_time(16'd20000);
    post_time(16'd45000);
    post_time(16'd65000);
    wait_drained();

    // random phases, each with a fresh config
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      logic [63:0] mode_val, count_val;
      rand_table();
      if (ph % 5 == 0)
        mode_val = 64'($urandom_range(0, 3));
      else
        mode_val = ($urandom_range(0, 2) == 0) ? 64'(MODE_STEP) : 64'(MODE_LINEAR);
      if ($urandom_range(0, 7) == 0) mode_val[63:2] = 62'($urandom);
      if (ph % 6 == 0)
        count_val = 64'($urandom_range(0, 7));
      else
        count_val = ($urandom_range(0, 1) == 0) ? 64'd6 : 64'($urandom_range(2, 6));
      write_table(mode_val, count_val);
      if (ph >= QUIET_FROM) quiet = 1'b1;
      if (ph == 1) hold_start = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        post_time(rand_query());
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && color_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/kcr_pkg.sv
rtl/kcr_div_stage.sv
rtl/keypoint_color_ramp_unit.sv
dv/tb.sv
